### hdl/dcnt_pkg.sv
// ----------------------------------------------------------------------------
// dcnt_pkg
// shared types, constants and helpers for the diamond region counter
// ----------------------------------------------------------------------------
package dcnt_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;
    localparam int DIM_W        = 7;
    localparam int COLOR_W      = 8;
    localparam int RUN_W        = 7;
    localparam int TOTAL_W      = 18;
    localparam int ADDR_MAX_W   = 20;
    localparam int CFG_IDX_W    = 2;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD_A,
        S_RD_B,
        S_CALC,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PASS_UL,
        PASS_UR,
        PASS_DL,
        PASS_DR
    } t_pass;

    typedef struct packed {
        logic                  cell_we;
        logic [ADDR_MAX_W-1:0] cell_waddr;
        logic [COLOR_W-1:0]    cell_wdata;
        logic [ADDR_MAX_W-1:0] rd_addr;
        logic                  run_we;
        t_pass                 run_sel;
        logic [ADDR_MAX_W-1:0] run_waddr;
        logic [RUN_W-1:0]      run_wdata;
    } t_mem_req;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [RUN_W-1:0]   ul;
        logic [RUN_W-1:0]   ur;
        logic [RUN_W-1:0]   dl;
    } t_mem_rsp;

    typedef struct packed {
        logic busy;
        logic at_origin;
        logic last_load;
    } t_status;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > maxv) begin
            r = DIM_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [RUN_W-1:0] min_run(input logic [RUN_W-1:0] a,
                                                  input logic [RUN_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

### hdl/dcnt_store.sv
// ----------------------------------------------------------------------------
// dcnt_store
// colour memory and the three run memories, registered read
// ----------------------------------------------------------------------------
module dcnt_store import dcnt_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [COLOR_W-1:0] m_color [DEPTH];
    logic [RUN_W-1:0]   m_ul    [DEPTH];
    logic [RUN_W-1:0]   m_ur    [DEPTH];
    logic [RUN_W-1:0]   m_dl    [DEPTH];

    logic [ADDR_W-1:0] rd_a;
    logic [ADDR_W-1:0] cw_a;
    logic [ADDR_W-1:0] rw_a;

    assign rd_a = i_req.rd_addr[ADDR_W-1:0];
    assign cw_a = i_req.cell_waddr[ADDR_W-1:0];
    assign rw_a = i_req.run_waddr[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.cell_we) begin
            m_color[cw_a] <= i_req.cell_wdata;
        end
        if (i_req.run_we && (i_req.run_sel == PASS_UL || i_req.run_sel == PASS_DR)) begin
            m_ul[rw_a] <= i_req.run_wdata;
        end
        if (i_req.run_we && i_req.run_sel == PASS_UR) begin
            m_ur[rw_a] <= i_req.run_wdata;
        end
        if (i_req.run_we && i_req.run_sel == PASS_DL) begin
            m_dl[rw_a] <= i_req.run_wdata;
        end
        o_rsp.color <= m_color[rd_a];
        o_rsp.ul    <= m_ul[rd_a];
        o_rsp.ur    <= m_ur[rd_a];
        o_rsp.dl    <= m_dl[rd_a];
    end

endmodule

### hdl/dcnt_ctrl.sv
// ----------------------------------------------------------------------------
// dcnt_ctrl
// load sequencer, four directional sweeps and the summing result register
// ----------------------------------------------------------------------------
module dcnt_ctrl import dcnt_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [DIM_W-1:0]   i_rows,
    input  logic [DIM_W-1:0]   i_cols,
    input  logic               i_restart,
    input  logic               i_cell_valid,
    output logic               o_cell_ready,
    input  logic [COLOR_W-1:0] i_cell_color,
    output logic               o_total_valid,
    input  logic               i_total_ready,
    output logic [TOTAL_W-1:0] o_diamond_total,
    output t_mem_req           o_req,
    input  t_mem_rsp           i_rsp,
    output t_status            o_status
);

    t_state r_state, n_state;
    t_pass  r_pass;
    logic [DIM_W-1:0]   r_row, r_col;
    logic [COLOR_W-1:0] r_color, r_prev_color;
    logic [RUN_W-1:0]   r_ul, r_ur, r_dl, r_prev_run;
    logic [TOTAL_W-1:0] r_sum;
    logic               r_out_valid;
    logic [TOTAL_W-1:0] r_out;

    logic [DIM_W-1:0] nr, nc;
    logic             fwd, top;
    logic [DIM_W-1:0] col_start, col_end, row_start, row_end;
    logic             vborder, hborder, row_last, col_last, pass_last;
    logic [ADDR_MAX_W-1:0] addr, vaddr;
    logic [RUN_W-1:0] vrun, run, m4;
    logic             match;
    logic [TOTAL_W:0] sum_ext;
    logic [TOTAL_W-1:0] sum_next;
    logic             accept, load_last, out_free, out_load;

    assign nr = clamp_dim(i_rows, MAX_ROWS);
    assign nc = clamp_dim(i_cols, MAX_COLS);

    assign fwd       = (r_pass == PASS_UL) || (r_pass == PASS_DL);
    assign top       = (r_pass == PASS_UL) || (r_pass == PASS_UR);
    assign col_start = fwd ? '0 : nc - DIM_W'(1);
    assign col_end   = fwd ? nc - DIM_W'(1) : '0;
    assign row_start = top ? '0 : nr - DIM_W'(1);
    assign row_end   = top ? nr - DIM_W'(1) : '0;
    assign vborder   = (r_row == row_start);
    assign hborder   = (r_col == col_start);
    assign col_last  = (r_col == col_end);
    assign row_last  = (r_row == row_end);
    assign pass_last = col_last && row_last;

    assign addr  = ADDR_MAX_W'(32'(r_row) * MAX_COLS + 32'(r_col));
    assign vaddr = top ? addr - ADDR_MAX_W'(MAX_COLS) : addr + ADDR_MAX_W'(MAX_COLS);

    always_comb begin
        case (r_pass)
            PASS_UR: vrun = i_rsp.ur;
            PASS_DL: vrun = i_rsp.dl;
            default: vrun = i_rsp.ul;
        endcase
    end

    assign match = (r_color == i_rsp.color) && (r_color == r_prev_color);
    assign run   = (vborder || hborder || !match) ? RUN_W'(1)
                                                  : min_run(vrun, r_prev_run) + RUN_W'(1);
    assign m4    = min_run(min_run(r_ul, r_ur), min_run(r_dl, run));

    assign sum_ext  = {1'b0, r_sum} + (TOTAL_W+1)'(m4);
    assign sum_next = sum_ext[TOTAL_W] ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];

    assign o_cell_ready = (r_state == S_LOAD);
    assign accept       = i_cell_valid && o_cell_ready;
    assign load_last    = (r_row == nr - DIM_W'(1)) && (r_col == nc - DIM_W'(1));
    assign out_free     = !r_out_valid || i_total_ready;
    assign out_load     = (r_state == S_CALC && r_pass == PASS_DR && pass_last && out_free)
                       || (r_state == S_DONE && out_free);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (accept && load_last && !i_restart) begin
                    n_state = S_RD_A;
                end
            end
            S_RD_A: n_state = S_RD_B;
            S_RD_B: n_state = S_CALC;
            S_CALC: begin
                if (r_pass == PASS_DR && pass_last) begin
                    n_state = out_free ? S_LOAD : S_DONE;
                end else begin
                    n_state = S_RD_A;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // memory requests
    always_comb begin
        o_req            = '0;
        o_req.cell_we    = accept;
        o_req.cell_waddr = addr;
        o_req.cell_wdata = i_cell_color;
        o_req.rd_addr    = (r_state == S_RD_B && !vborder) ? vaddr : addr;
        o_req.run_we     = (r_state == S_CALC);
        o_req.run_sel    = r_pass;
        o_req.run_waddr  = addr;
        o_req.run_wdata  = run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_pass      <= PASS_UL;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_total_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (i_restart) begin
                        r_row <= '0;
                        r_col <= '0;
                    end else if (accept) begin
                        if (load_last) begin
                            r_row  <= '0;
                            r_col  <= '0;
                            r_pass <= PASS_UL;
                        end else if (r_col == nc - DIM_W'(1)) begin
                            r_col <= '0;
                            r_row <= r_row + DIM_W'(1);
                        end else begin
                            r_col <= r_col + DIM_W'(1);
                        end
                    end
                end
                S_CALC: begin
                    if (pass_last) begin
                        unique case (r_pass)
                            PASS_UL: begin
                                r_pass <= PASS_UR;
                                r_row  <= '0;
                                r_col  <= nc - DIM_W'(1);
                            end
                            PASS_UR: begin
                                r_pass <= PASS_DL;
                                r_row  <= nr - DIM_W'(1);
                                r_col  <= '0;
                            end
                            PASS_DL: begin
                                r_pass <= PASS_DR;
                                r_row  <= nr - DIM_W'(1);
                                r_col  <= nc - DIM_W'(1);
                            end
                            default: begin
                                r_pass <= PASS_UL;
                                r_row  <= '0;
                                r_col  <= '0;
                            end
                        endcase
                    end else if (col_last) begin
                        r_col <= col_start;
                        r_row <= top ? r_row + DIM_W'(1) : r_row - DIM_W'(1);
                    end else begin
                        r_col <= fwd ? r_col + DIM_W'(1) : r_col - DIM_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD_B) begin
            r_color <= i_rsp.color;
            r_ul    <= i_rsp.ul;
            r_ur    <= i_rsp.ur;
            r_dl    <= i_rsp.dl;
        end
        if (r_state == S_CALC) begin
            r_prev_color <= r_color;
            r_prev_run   <= run;
            if (r_pass == PASS_DR) begin
                r_sum <= sum_next;
            end else if (r_pass == PASS_DL && pass_last) begin
                r_sum <= '0;
            end
        end
        if (out_load) begin
            r_out <= (r_state == S_CALC) ? sum_next : r_sum;
        end
    end

    assign o_total_valid   = r_out_valid;
    assign o_diamond_total = r_out;

    assign o_status.busy      = (r_state != S_LOAD);
    assign o_status.at_origin = (r_row == '0) && (r_col == '0);
    assign o_status.last_load = accept && load_last && !i_restart;

endmodule

### hdl/diamond_region_count.sv
// ----------------------------------------------------------------------------
// diamond_region_count
// counts same-colour diamonds over a grid of colour codes
// ----------------------------------------------------------------------------
// Cells are taken one per cycle in row-major order until grid_rows x
// grid_cols have arrived. The block then makes four sweeps over the grid
// (up-left, up-right, down-left, down-right with summing), each cell being
// handled by one read of the cell, one read of its vertical neighbour
// through the single read port of each memory, and one write-back. Input is
// refused during the sweeps; the total sits in an output register so loading
// of the next grid can start while it waits.
module diamond_region_count import dcnt_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_cell_valid,
    output logic                 o_cell_ready,
    input  logic [COLOR_W-1:0]   i_cell_color,
    output logic                 o_total_valid,
    input  logic                 i_total_ready,
    output logic [TOTAL_W-1:0]   o_diamond_total
);

    logic [DIM_W-1:0] r_rows, r_cols;
    logic             restart;
    t_mem_req         req;
    t_mem_rsp         rsp;
    t_status          status;

    assign restart = i_cfg_we && (i_cfg_idx == CFG_ROWS || i_cfg_idx == CFG_COLS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= DIM_W'(64);
            r_cols <= DIM_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS: r_rows <= i_cfg_data;
                CFG_COLS: r_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dcnt_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rows          (r_rows),
        .i_cols          (r_cols),
        .i_restart       (restart),
        .i_cell_valid    (i_cell_valid),
        .o_cell_ready    (o_cell_ready),
        .i_cell_color    (i_cell_color),
        .o_total_valid   (o_total_valid),
        .i_total_ready   (i_total_ready),
        .o_diamond_total (o_diamond_total),
        .o_req           (req),
        .i_rsp           (rsp),
        .o_status        (status)
    );

    dcnt_store #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_store (
        .i_clk (i_clk),
        .i_req (req),
        .o_rsp (rsp)
    );

    a_sweep_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.last_load |=> !o_cell_ready && status.at_origin)
        else $error("sweep did not start after the last cell transfer");

    a_ready_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cell_ready == !status.busy)
        else $error("input ready disagrees with sequencer state");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart && !status.busy |=> status.at_origin)
        else $error("register write did not drop the partial grid");

endmodule
